@@ rtl/drpu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpu_pkg
// Shared constants, types and the arctangent table for the pose update unit.
// ----------------------------------------------------------------------------
package drpu_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int FRACTION_BITS     = 16;
    localparam int POSE_FRACTION     = 16;

    localparam int POSE_W  = 48;
    localparam int ANGLE_W = 32;
    localparam int GAIN_W  = 24;
    localparam int STEP_W  = 16;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 8;

    // CORDIC vector width: unit magnitude plus gain headroom and sign.
    localparam int CORD_W = FRACTION_BITS + 3;
    // Residual angle width, one bit above a full binary angle.
    localparam int Z_W    = ANGLE_W + 1;
    localparam int CNT_W  = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

    localparam longint K_Q30  = 64'd652032874;
    localparam longint K_INIT = (K_Q30 + (longint'(1) << (29 - FRACTION_BITS)))
                                >> (30 - FRACTION_BITS);

    // Shared multiplier operands: A is signed (cos/sin or step magnitude),
    // B is signed (steps or zero-extended gain).
    localparam int MUL_A_W = (CORD_W > STEP_W + 2) ? CORD_W : STEP_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Scaling of a product to the pose fraction.
    localparam int SCALE_SHR = (FRACTION_BITS > POSE_FRACTION) ?
                               FRACTION_BITS - POSE_FRACTION : 0;
    localparam int SCALE_SHL = (FRACTION_BITS > POSE_FRACTION) ?
                               0 : POSE_FRACTION - FRACTION_BITS;
    localparam int SUM_W     = ((MUL_P_W > POSE_W) ? MUL_P_W : POSE_W) + 2;

    localparam logic [INDEX_W-1:0] REG_RIGHT_GAIN = 8'd0;
    localparam logic [INDEX_W-1:0] REG_LEFT_GAIN  = 8'd1;

    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TURN     = 2'd1;

    localparam logic [GAIN_W-1:0] RIGHT_GAIN_RESET = 24'd884466;
    localparam logic [GAIN_W-1:0] LEFT_GAIN_RESET  = 24'd863137;

    typedef struct packed {
        logic                     done;
        logic signed [CORD_W-1:0] cos_val;
        logic signed [CORD_W-1:0] sin_val;
    } drpu_sincos_t;

    // atan(2^-i) as a binary angle, full turn = 2^32.
    function automatic logic [Z_W-1:0] atan_angle(input int idx);
        logic [31:0] a;
        begin
            unique case (idx)
                0:  a = 32'd536870912;
                1:  a = 32'd316933406;
                2:  a = 32'd167458907;
                3:  a = 32'd85004756;
                4:  a = 32'd42667331;
                5:  a = 32'd21354465;
                6:  a = 32'd10679838;
                7:  a = 32'd5340245;
                8:  a = 32'd2670163;
                9:  a = 32'd1335087;
                10: a = 32'd667544;
                11: a = 32'd333772;
                12: a = 32'd166886;
                13: a = 32'd83443;
                14: a = 32'd41722;
                15: a = 32'd20861;
                16: a = 32'd10430;
                17: a = 32'd5215;
                18: a = 32'd2608;
                19: a = 32'd1304;
                20: a = 32'd652;
                21: a = 32'd326;
                22: a = 32'd163;
                23: a = 32'd81;
                24: a = 32'd41;
                25: a = 32'd20;
                26: a = 32'd10;
                27: a = 32'd5;
                28: a = 32'd3;
                29: a = 32'd1;
                default: a = 32'd0;
            endcase
            return {1'b0, a};
        end
    endfunction

endpackage

@@ rtl/dead_reckoning_pose_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_reckoning_pose_update_unit
// Keeps an x/y/heading pose and updates it from wheel step reports.
// ----------------------------------------------------------------------------
// A straight move steps S_SINCOS, S_MUL_C, S_ADD_X, S_MUL_S, S_ADD_Y and S_EMIT;
// a turn steps S_TURN_MUL, S_TURN_ADD and S_EMIT; any other mode goes to S_EMIT.
// The iterative CORDIC and one shared multiplier set this order; one item
// is in flight at a time, as the input is ready only in S_IDLE.
// A result waiting for m_tready holds the next item in S_EMIT; the input stalls too.
// Reset clears the pose to zero and loads the default turn gains.
module dead_reckoning_pose_update_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream. tdata: left_wheel_steps[15:0], right_wheel_steps[31:16].
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,
    // tuser: mode[1:0].
    input  logic [drpu_pkg::MODE_W-1:0]      s_tuser,
    // Result stream. tdata: x_position[47:0], y_position[95:48],
    // heading_angle[127:96].
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [127:0]                     m_tdata,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [drpu_pkg::INDEX_W-1:0]     cfg_index,
    input  logic [drpu_pkg::GAIN_W-1:0]      cfg_data
);
    import drpu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINCOS,
        S_MUL_C,
        S_ADD_X,
        S_MUL_S,
        S_ADD_Y,
        S_TURN_MUL,
        S_TURN_ADD,
        S_EMIT
    } seq_state_t;

    localparam logic signed [SUM_W-1:0] POSE_MAX_EXT =
        SUM_W'({1'b0, {(POSE_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] POSE_MIN_EXT =
        -POSE_MAX_EXT - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        (SCALE_SHR > 0) ? (SUM_W'(1) << (SCALE_SHR - 1)) : '0;

    seq_state_t                state_reg;
    logic signed [STEP_W-1:0]  left_reg;
    logic signed [STEP_W-1:0]  right_reg;
    logic signed [CORD_W-1:0]  cos_reg;
    logic signed [CORD_W-1:0]  sin_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [POSE_W-1:0]  pose_x_reg;
    logic signed [POSE_W-1:0]  pose_y_reg;
    logic [ANGLE_W-1:0]        heading_reg;
    logic [GAIN_W-1:0]         right_gain_reg;
    logic [GAIN_W-1:0]         left_gain_reg;
    logic                      out_valid_reg;
    logic [127:0]              out_data_reg;

    logic                      in_xfer;
    logic                      cordic_start;
    drpu_sincos_t              sincos;
    logic signed [STEP_W:0]    diff;
    logic                      diff_neg;
    logic signed [STEP_W+1:0]  diff_mag;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [SUM_W-1:0]   delta;
    logic signed [SUM_W-1:0]   pose_sel;
    logic signed [SUM_W-1:0]   pose_sum;
    logic signed [POSE_W-1:0]  pose_sat;
    logic                      out_free;

    assign s_tready     = (state_reg == S_IDLE);
    assign in_xfer      = s_tvalid && s_tready;
    assign cordic_start = in_xfer && (s_tuser == MODE_STRAIGHT);
    assign cfg_ready    = 1'b1;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign out_free     = !out_valid_reg || m_tready;

    drpu_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (heading_reg),
        .result (sincos)
    );

    // Shared multiplier operand selection and the pose accumulate path.
    always_comb
    begin
        diff     = (STEP_W+1)'(right_reg) - (STEP_W+1)'(left_reg);
        diff_neg = diff[STEP_W];
        diff_mag = diff_neg ? -(STEP_W+2)'(diff) : (STEP_W+2)'(diff);

        unique case (state_reg)
            S_MUL_C:
            begin
                mul_a = MUL_A_W'(cos_reg);
                mul_b = MUL_B_W'(left_reg);
            end
            S_MUL_S:
            begin
                mul_a = MUL_A_W'(sin_reg);
                mul_b = MUL_B_W'(left_reg);
            end
            default:
            begin
                mul_a = MUL_A_W'(diff_mag);
                mul_b = diff_neg ? $signed({1'b0, left_gain_reg})
                                 : $signed({1'b0, right_gain_reg});
            end
        endcase
        mul_p = MUL_P_W'(mul_a * mul_b);

        delta    = ((SUM_W'(prod_reg) + ROUND_HALF) >>> SCALE_SHR) <<< SCALE_SHL;
        pose_sel = (state_reg == S_ADD_Y) ? SUM_W'(pose_y_reg) : SUM_W'(pose_x_reg);
        pose_sum = pose_sel + delta;
        if (pose_sum > POSE_MAX_EXT)
        begin
            pose_sat = POSE_MAX_EXT[POSE_W-1:0];
        end
        else if (pose_sum < POSE_MIN_EXT)
        begin
            pose_sat = POSE_MIN_EXT[POSE_W-1:0];
        end
        else
        begin
            pose_sat = pose_sum[POSE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            left_reg       <= '0;
            right_reg      <= '0;
            cos_reg        <= '0;
            sin_reg        <= '0;
            prod_reg       <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            heading_reg    <= '0;
            right_gain_reg <= RIGHT_GAIN_RESET;
            left_gain_reg  <= LEFT_GAIN_RESET;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RIGHT_GAIN)
                begin
                    right_gain_reg <= cfg_data;
                end
                else if (cfg_index == REG_LEFT_GAIN)
                begin
                    left_gain_reg <= cfg_data;
                end
            end

            // In S_EMIT a completed result transfer is replaced by the new one.
            if (out_valid_reg && m_tready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        left_reg  <= $signed(s_tdata[STEP_W-1:0]);
                        right_reg <= $signed(s_tdata[2*STEP_W-1:STEP_W]);
                        if (s_tuser == MODE_STRAIGHT)
                        begin
                            state_reg <= S_SINCOS;
                        end
                        else if (s_tuser == MODE_TURN)
                        begin
                            state_reg <= S_TURN_MUL;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SINCOS:
                begin
                    if (sincos.done)
                    begin
                        cos_reg   <= sincos.cos_val;
                        sin_reg   <= sincos.sin_val;
                        state_reg <= S_MUL_C;
                    end
                end
                S_MUL_C:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ADD_X;
                end
                S_ADD_X:
                begin
                    pose_x_reg <= pose_sat;
                    state_reg  <= S_MUL_S;
                end
                S_MUL_S:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ADD_Y;
                end
                S_ADD_Y:
                begin
                    pose_y_reg <= pose_sat;
                    state_reg  <= S_EMIT;
                end
                S_TURN_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_TURN_ADD;
                end
                S_TURN_ADD:
                begin
                    // A zero difference gives a zero product, so the heading holds.
                    if (diff_neg)
                    begin
                        heading_reg <= heading_reg - prod_reg[ANGLE_W-1:0];
                    end
                    else
                    begin
                        heading_reg <= heading_reg + prod_reg[ANGLE_W-1:0];
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {heading_reg, pose_y_reg, pose_x_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/drpu_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpu_cordic
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module drpu_cordic (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [drpu_pkg::ANGLE_W-1:0]    angle,
    output drpu_pkg::drpu_sincos_t          result
);
    import drpu_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_DONE
    } cordic_state_t;

    cordic_state_t            state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               quad_reg;
    logic signed [CORD_W-1:0] x_reg;
    logic signed [CORD_W-1:0] y_reg;
    logic signed [Z_W-1:0]    z_reg;

    logic [ANGLE_W-1:0]       turned;
    logic signed [Z_W-1:0]    z_start;
    logic signed [CORD_W-1:0] x_shift;
    logic signed [CORD_W-1:0] y_shift;
    logic signed [Z_W-1:0]    atan_step;

    // Shift the angle by an eighth turn so that the top two bits pick the
    // nearest quarter and the rest is the residual around it.
    always_comb
    begin
        turned    = angle + 32'h2000_0000;
        z_start   = $signed({3'b000, turned[ANGLE_W-3:0]}) - $signed(Z_W'(33'h2000_0000));
        x_shift   = x_reg >>> cnt_reg;
        y_shift   = y_reg >>> cnt_reg;
        atan_step = $signed(atan_angle(int'(cnt_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            quad_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        quad_reg  <= turned[ANGLE_W-1:ANGLE_W-2];
                        z_reg     <= z_start;
                        x_reg     <= CORD_W'(K_INIT);
                        y_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    if (!z_reg[Z_W-1])
                    begin
                        x_reg <= x_reg - y_shift;
                        y_reg <= y_reg + x_shift;
                        z_reg <= z_reg - atan_step;
                    end
                    else
                    begin
                        x_reg <= x_reg + y_shift;
                        y_reg <= y_reg - x_shift;
                        z_reg <= z_reg + atan_step;
                    end
                    if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1))
                    begin
                        state_reg <= C_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                C_DONE:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // Rotate the result back by the quarter turns that were taken off.
    always_comb
    begin
        result.done = (state_reg == C_DONE);
        unique case (quad_reg)
            2'd0:
            begin
                result.cos_val = x_reg;
                result.sin_val = y_reg;
            end
            2'd1:
            begin
                result.cos_val = -y_reg;
                result.sin_val = x_reg;
            end
            2'd2:
            begin
                result.cos_val = -x_reg;
                result.sin_val = -y_reg;
            end
            default:
            begin
                result.cos_val = y_reg;
                result.sin_val = -x_reg;
            end
        endcase
    end

endmodule

@@ tb/sv/tb_dead_reckoning_pose_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dead_reckoning_pose_update_unit
// This testbench checks the pose update unit against its own pose tracker,
// which mirrors the CORDIC, the turn gains and the saturating x/y sums. A
// directed table runs first. Random phases follow, each under its own pair of
// turn gains. A run of full forward steps along a diagonal heading and a short random run close it.
// Both stream sides stall at random, and each result transfer is compared
// field by field with the oldest predicted pose.
// ----------------------------------------------------------------------------
module tb_dead_reckoning_pose_update_unit;

    import drpu_pkg::*;

    localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam longint POSE_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POSE_MIN      = -POSE_MAX - 1;
    localparam longint CORDIC_X_INIT =
        (64'd652032874 + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    localparam int     SETTLE_CYCLES = 32;

    typedef struct packed {
        logic signed [POSE_W-1:0] x;
        logic signed [POSE_W-1:0] y;
        logic [ANGLE_W-1:0]       heading;
    } pose_t;

    typedef struct packed {
        logic signed [STEP_W-1:0] left;
        logic signed [STEP_W-1:0] right;
        logic [MODE_W-1:0]        mode;
        logic                     typed;
        pose_t                    pose;
    } step_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [MODE_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [127:0]         m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [INDEX_W-1:0]   cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data  = '0;

    // Pose tracker state and its copy of the gain registers.
    longint               track_x;
    longint               track_y;
    logic [ANGLE_W-1:0]   track_heading;
    logic [GAIN_W-1:0]    track_right_gain;
    logic [GAIN_W-1:0]    track_left_gain;

    pose_t                pending_poses[$];
    pose_t                oldest_pose;
    bit                   steady = 1'b0;
    int                   mismatch_count = 0;
    int                   results_checked = 0;
    int                   transfers_sent = 0;
    int                   gain_settings = 1;

    longint atan_step [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    // Typed poses hold only while the gains are at their reset values.
    step_row_t directed_rows [16] = '{
        '{16'sd0,      16'sd0,      MODE_HOLD,     1'b1, '{48'sd0, 48'sd0, 32'd0}},
        '{16'sh8000,   16'sh7FFF,   MODE_SPARE,    1'b1, '{48'sd0, 48'sd0, 32'd0}},
        '{16'sd0,      16'sh7FFF,   MODE_STRAIGHT, 1'b1, '{48'sd0, 48'sd0, 32'd0}},
        '{16'sd7,      16'sd7,      MODE_TURN,     1'b1, '{48'sd0, 48'sd0, 32'd0}},
        '{16'sd0,      16'sd1,      MODE_TURN,     1'b1, '{48'sd0, 48'sd0, 32'd884466}},
        '{16'sd1,      16'sd0,      MODE_TURN,     1'b1, '{48'sd0, 48'sd0, 32'd21329}},
        '{16'sd0,      -16'sd1,     MODE_TURN,     1'b1,
          '{48'sd0, 48'sd0, 32'd4294125488}},
        '{16'sh7FFF,   16'sh8000,   MODE_STRAIGHT, 1'b0, '0},
        '{16'sh8000,   16'sh7FFF,   MODE_STRAIGHT, 1'b0, '0},
        '{16'sh8000,   16'sh7FFF,   MODE_TURN,     1'b0, '0},
        '{16'sd1000,   16'sd0,      MODE_STRAIGHT, 1'b0, '0},
        '{16'sh7FFF,   16'sh8000,   MODE_TURN,     1'b0, '0},
        '{-16'sd1,     -16'sd1,     MODE_STRAIGHT, 1'b0, '0},
        '{16'sd0,      16'sd0,      MODE_TURN,     1'b0, '0},
        '{16'sd12345,  -16'sd12345, MODE_HOLD,     1'b0, '0},
        '{16'sd1,      16'sd0,      MODE_STRAIGHT, 1'b0, '0}
    };

    dead_reckoning_pose_update_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 17);
    end

    // The quarter turn nearest the heading is taken out first, so the CORDIC
    // only sees a residual within one eighth of a turn.
    function automatic void heading_sin_cos(input logic [ANGLE_W-1:0] ang,
                                            output longint c, output longint s);
        logic [ANGLE_W-1:0] t;
        longint             z;
        longint             cx;
        longint             cy;
        longint             xs;
        longint             ys;
        t  = ang + 32'h2000_0000;
        z  = longint'(t[29:0]) - 64'sd536870912;
        cx = CORDIC_X_INIT;
        cy = 0;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 30; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0)
            begin
                cx = cx - ys;
                cy = cy + xs;
                z  = z - atan_step[i];
            end
            else
            begin
                cx = cx + ys;
                cy = cy - xs;
                z  = z + atan_step[i];
            end
        end
        case (t[31:30])
            2'd0:    begin c = cx;  s = cy;  end
            2'd1:    begin c = -cy; s = cx;  end
            2'd2:    begin c = -cx; s = -cy; end
            default: begin c = cy;  s = -cx; end
        endcase
    endfunction

    function automatic longint scale_to_pose(input longint p);
        if (FRACTION_BITS > POSE_FRACTION)
            return (p + (64'sd1 << (FRACTION_BITS - POSE_FRACTION - 1)))
                   >>> (FRACTION_BITS - POSE_FRACTION);
        return p * (64'sd1 << (POSE_FRACTION - FRACTION_BITS));
    endfunction

    function automatic longint clamp_pose(input longint a, input longint b);
        longint r;
        r = a + b;
        if (r > POSE_MAX)
            return POSE_MAX;
        if (r < POSE_MIN)
            return POSE_MIN;
        return r;
    endfunction

    function automatic void advance_pose(input logic signed [STEP_W-1:0] left,
                                         input logic signed [STEP_W-1:0] right,
                                         input logic [MODE_W-1:0] mode);
        longint c;
        longint s;
        longint diff;
        longint turn;
        if (mode == MODE_STRAIGHT)
        begin
            heading_sin_cos(track_heading, c, s);
            track_x = clamp_pose(track_x, scale_to_pose(c * longint'(left)));
            track_y = clamp_pose(track_y, scale_to_pose(s * longint'(left)));
        end
        else if (mode == MODE_TURN)
        begin
            diff = longint'(right) - longint'(left);
            if (diff > 0)
            begin
                turn          = diff * longint'(track_right_gain);
                track_heading = track_heading + turn[31:0];
            end
            else if (diff < 0)
            begin
                turn          = -diff * longint'(track_left_gain);
                track_heading = track_heading - turn[31:0];
            end
        end
    endfunction

    function automatic logic [STEP_W-1:0] pick_steps();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Called at a clock edge; returns at the edge that carries the transfer.
    task automatic send_item(input logic signed [STEP_W-1:0] left,
                             input logic signed [STEP_W-1:0] right,
                             input logic [MODE_W-1:0] mode,
                             input logic typed, input pose_t typed_pose);
        pose_t predicted;
        int    gap;
        if (!steady && $urandom_range(99) < 17)
        begin
            gap = $urandom_range(1, 30);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                s_tuser  <= 2'($urandom);
                @(posedge clk);
            end
        end
        s_tdata  <= {right, left};
        s_tuser  <= mode;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        advance_pose(left, right, mode);
        predicted.x       = track_x[POSE_W-1:0];
        predicted.y       = track_y[POSE_W-1:0];
        predicted.heading = track_heading;
        pending_poses.push_back(typed ? typed_pose : predicted);
        transfers_sent++;
    endtask

    // Leaves the input idle until every pose is back and the unit has settled.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_gain(input logic [INDEX_W-1:0] index,
                              input logic [GAIN_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_RIGHT_GAIN)
            track_right_gain = value;
        else if (index == REG_LEFT_GAIN)
            track_left_gain = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int                roll;
        logic [MODE_W-1:0] mode;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 42)
                mode = MODE_STRAIGHT;
            else if (roll < 82)
                mode = MODE_TURN;
            else if (roll < 95)
                mode = MODE_HOLD;
            else
                mode = MODE_SPARE;
            send_item(pick_steps(), pick_steps(), mode, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("result transfer with no pose pending: %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                oldest_pose = pending_poses.pop_front();
                results_checked++;
                if (m_tdata[47:0] !== oldest_pose.x)
                begin
                    $error("x_position: expected %0d, actual %0d",
                           oldest_pose.x, $signed(m_tdata[47:0]));
                    mismatch_count++;
                end
                if (m_tdata[95:48] !== oldest_pose.y)
                begin
                    $error("y_position: expected %0d, actual %0d",
                           oldest_pose.y, $signed(m_tdata[95:48]));
                    mismatch_count++;
                end
                if (m_tdata[127:96] !== oldest_pose.heading)
                begin
                    $error("heading_angle: expected %0d, actual %0d",
                           oldest_pose.heading, m_tdata[127:96]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [ANGLE_W-1:0] to_diagonal;
        track_x          = 0;
        track_y          = 0;
        track_heading    = '0;
        track_right_gain = 24'd884466;
        track_left_gain  = 24'd863137;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < $size(directed_rows); r++)
            send_item(directed_rows[r].left, directed_rows[r].right,
                      directed_rows[r].mode, directed_rows[r].typed,
                      directed_rows[r].pose);
        run_random(400);

        drain_results();
        write_gain(REG_RIGHT_GAIN, 24'd0);
        write_gain(REG_LEFT_GAIN, 24'hFF_FFFF);
        gain_settings++;
        steady = 1'b1;
        run_random(300);
        steady = 1'b0;

        // Writes to indexes past the gain pair must leave both gains alone.
        drain_results();
        write_gain(REG_RIGHT_GAIN, 24'hFF_FFFF);
        write_gain(REG_LEFT_GAIN, 24'd0);
        write_gain(8'd2, 24'($urandom));
        write_gain(8'hFF, 24'($urandom));
        gain_settings++;
        run_random(300);

        drain_results();
        write_gain(REG_RIGHT_GAIN, 24'($urandom));
        write_gain(REG_LEFT_GAIN, 24'($urandom));
        gain_settings++;
        run_random(300);

        drain_results();
        write_gain(REG_RIGHT_GAIN, 24'($urandom_range(255)));
        write_gain(REG_LEFT_GAIN, 24'($urandom_range(255)));
        gain_settings++;
        run_random(300);

        // Steer to 135 degrees in two right turns, coarse then fine.
        drain_results();
        to_diagonal = 32'h6000_0000 - track_heading;
        write_gain(REG_RIGHT_GAIN, 24'd65536);
        send_item(16'sh8000, 16'(int'(to_diagonal[31:16]) - 32768), MODE_TURN, 1'b0, '0);
        drain_results();
        write_gain(REG_RIGHT_GAIN, 24'd1);
        gain_settings++;
        send_item(16'sh8000, 16'(int'(to_diagonal[15:0]) - 32768), MODE_TURN, 1'b0, '0);

        // Full forward steps along the diagonal, back to back.
        steady = 1'b1;
        repeat (40)
            send_item(16'sh7FFF, 16'($urandom), MODE_STRAIGHT, 1'b0, '0);
        steady = 1'b0;
        run_random(8);

        drain_results();
        $display("Summary: %0d input transfers, %0d poses checked under %0d gain settings,",
                 transfers_sent, results_checked, gain_settings);
        $display("Summary: all modes, step extremes, stray register indexes, a diagonal heading.");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #(100_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ dead_reckoning_pose_update_unit.f @@
rtl/drpu_pkg.sv
rtl/drpu_cordic.sv
rtl/dead_reckoning_pose_update_unit.sv
tb/sv/tb_dead_reckoning_pose_update_unit.sv
